// ===== sv/versatile_interface_adapter_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef VERSATILE_INTERFACE_ADAPTER_CORE_ASSERT_SVH
`define VERSATILE_INTERFACE_ADAPTER_CORE_ASSERT_SVH
// Implication on the same edge.
`define VIA_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: check failed");
// Implication on the next edge.
`define VIA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: check failed");
`endif

// ===== sv/via_pkg.sv =====
package via_pkg;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_TICK   = 3'd2,
        OP_PINS   = 3'd3,
        OP_LINE1  = 3'd4,
        OP_LINE2  = 3'd5,
        OP_SPARE6 = 3'd6,
        OP_SPARE7 = 3'd7
    } via_op_t;

    localparam logic [3:0] R_ORB  = 4'd0;
    localparam logic [3:0] R_ORA  = 4'd1;
    localparam logic [3:0] R_DDRB = 4'd2;
    localparam logic [3:0] R_DDRA = 4'd3;
    localparam logic [3:0] R_T1CL = 4'd4;
    localparam logic [3:0] R_T1CH = 4'd5;
    localparam logic [3:0] R_T1LL = 4'd6;
    localparam logic [3:0] R_T1LH = 4'd7;
    localparam logic [3:0] R_T2CL = 4'd8;
    localparam logic [3:0] R_T2CH = 4'd9;
    localparam logic [3:0] R_SR   = 4'd10;
    localparam logic [3:0] R_ACR  = 4'd11;
    localparam logic [3:0] R_PCR  = 4'd12;
    localparam logic [3:0] R_IFR  = 4'd13;
    localparam logic [3:0] R_IER  = 4'd14;
    localparam logic [3:0] R_ORAN = 4'd15;

    localparam int FL_CA2 = 0;
    localparam int FL_CA1 = 1;
    localparam int FL_SR  = 2;
    localparam int FL_CB2 = 3;
    localparam int FL_CB1 = 4;
    localparam int FL_T2  = 5;
    localparam int FL_T1  = 6;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] reg_index;
        logic [7:0] data_value;
        logic       port_select;
        logic       line_level;
    } via_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
        logic       ca1_level;
        logic       cb1_line;
        logic       ca2_line;
        logic       cb2_line;
        logic [6:0] interrupt_flags;
    } via_out_t;

endpackage

// ===== sv/via_if.sv =====
interface via_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/versatile_interface_adapter_core.sv =====
// Versatile interface adapter core.
// The in channel carries one word per operation: a bus read or write of one of
// sixteen registers, one emulated clock tick, new external pins for one port, or a
// new level on control line 1 or 2 of one side. The out channel returns one word for
// each input word: read data, pin states, the CA1 level, driven line levels, interrupt flags and irq.
// The state and the result register are updated at the edge at which the input word
// is accepted, and the result is offered from the next cycle.
// Throughput is one word per cycle while out.ready holds, set by the single pass of update logic.
// in.ready is high whenever the result register is empty or being emptied, so a
// stalled receiver holds the current result and stops new input for as long as it
// stalls, without losing or repeating any word.
// Reset clears the state registers, sets the line levels to one and empties the result.
module versatile_interface_adapter_core
    import via_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    via_if.sink   in,
    via_if.source out
);

    // Architectural registers.
    logic [7:0]  ora_reg, orb_reg, ddra_reg, ddrb_reg, lata_reg, latb_reg, pina_reg, pinb_reg;
    logic [15:0] t1c_reg, t2c_reg, sdiv_reg;
    logic [7:0]  t1ll_reg, t1lh_reg, t2ll_reg, sdat_reg, acr_reg, pcr_reg;
    logic        t1run_reg, t2run_reg, srun_reg, ca2p_reg, cb2p_reg;
    logic [3:0]  sbits_reg;
    logic [6:0]  ifr_reg, ier_reg, lv_reg;

    logic [7:0]  ora_next, orb_next, ddra_next, ddrb_next, lata_next, latb_next;
    logic [7:0]  pina_next, pinb_next;
    logic [15:0] t1c_next, t2c_next, sdiv_next;
    logic [7:0]  t1ll_next, t1lh_next, t2ll_next, sdat_next, acr_next, pcr_next;
    logic        t1run_next, t2run_next, srun_next, ca2p_next, cb2p_next;
    logic [3:0]  sbits_next;
    logic [6:0]  ifr_next, ier_next, lv_next;
    logic [7:0]  rd_next;

    via_out_t res_reg, res_next;
    logic     full_reg;
    logic     take;

    assign in.ready  = !full_reg || out.ready;
    assign take      = in.valid && in.ready;
    assign out.valid = full_reg;
    assign out.data  = res_reg;

    // Line level bits: 0 CA1 in, 1 CA2 in, 2 CB1 in, 3 CB2 in, 4 CA2 out, 5 CB2 out,
    // 6 CB1 out.
    always_comb
    begin
        logic [2:0] srm, pam, pbm;
        logic [3:0] bits;
        logic       sbit, act, ext;
        logic [7:0] ina, inb;
        via_in_t    w;
        w = in.data;
        ora_next = ora_reg; orb_next = orb_reg; ddra_next = ddra_reg; ddrb_next = ddrb_reg;
        lata_next = lata_reg; latb_next = latb_reg; pina_next = pina_reg;
        pinb_next = pinb_reg; t1c_next = t1c_reg; t2c_next = t2c_reg;
        sdiv_next = sdiv_reg; t1ll_next = t1ll_reg; t1lh_next = t1lh_reg;
        t2ll_next = t2ll_reg; sdat_next = sdat_reg; acr_next = acr_reg;
        pcr_next = pcr_reg; t1run_next = t1run_reg; t2run_next = t2run_reg;
        srun_next = srun_reg; ca2p_next = ca2p_reg; cb2p_next = cb2p_reg;
        sbits_next = sbits_reg; ifr_next = ifr_reg; ier_next = ier_reg;
        lv_next = lv_reg; rd_next = 8'h00;
        srm = acr_reg[4:2]; pam = pcr_reg[3:1]; pbm = pcr_reg[7:5];
        ext = (srm == 3'd3) || (srm == 3'd7);
        ina = acr_reg[0] ? lata_reg : pina_reg;
        inb = acr_reg[1] ? latb_reg : pinb_reg;
        bits = 4'd0; sbit = 1'b0; act = 1'b0;
        unique case (via_op_t'(w.operation))
            OP_READ, OP_WRITE:
            begin
                // ORA/ORB accesses clear own flags per PCR mode and run the line 2 handshake (ORB only with SR off).
                if (w.reg_index == R_ORA
                    || (w.operation == OP_WRITE && w.reg_index == R_ORB && 1'b0))
                begin
                end
                unique case (w.reg_index)
                    R_ORB:
                    begin
                        ifr_next[FL_CB1] = 1'b0;
                        if (pbm != 3'd1 && pbm != 3'd3) ifr_next[FL_CB2] = 1'b0;
                        if (srm == 3'd0)
                        begin
                            if (pbm == 3'd4 || pbm == 3'd5) lv_next[5] = 1'b0;
                            if (pbm == 3'd5) cb2p_next = 1'b1;
                        end
                        if (w.operation == OP_WRITE) orb_next = w.data_value;
                        else rd_next = (orb_reg & ddrb_reg) | (inb & ~ddrb_reg);
                    end
                    R_ORA:
                    begin
                        ifr_next[FL_CA1] = 1'b0;
                        if (pam != 3'd1 && pam != 3'd3) ifr_next[FL_CA2] = 1'b0;
                        if (pam == 3'd4 || pam == 3'd5) lv_next[4] = 1'b0;
                        if (pam == 3'd5) ca2p_next = 1'b1;
                        if (w.operation == OP_WRITE) ora_next = w.data_value;
                        else rd_next = (ora_reg & ddra_reg) | (ina & ~ddra_reg);
                    end
                    R_DDRB:
                        if (w.operation == OP_WRITE) ddrb_next = w.data_value;
                        else rd_next = ddrb_reg;
                    R_DDRA:
                        if (w.operation == OP_WRITE) ddra_next = w.data_value;
                        else rd_next = ddra_reg;
                    R_T1CL:
                        if (w.operation == OP_WRITE) t1ll_next = w.data_value;
                        else
                        begin
                            ifr_next[FL_T1] = 1'b0;
                            rd_next = t1c_reg[7:0];
                        end
                    R_T1CH:
                        if (w.operation == OP_WRITE)
                        begin
                            t1lh_next = w.data_value;
                            t1c_next = {w.data_value, t1ll_reg};
                            ifr_next[FL_T1] = 1'b0;
                            t1run_next = 1'b1;
                        end
                        else rd_next = t1c_reg[15:8];
                    R_T1LL:
                        if (w.operation == OP_WRITE) t1ll_next = w.data_value;
                        else rd_next = t1ll_reg;
                    R_T1LH:
                        if (w.operation == OP_WRITE)
                        begin
                            t1lh_next = w.data_value;
                            ifr_next[FL_T1] = 1'b0;
                        end
                        else rd_next = t1lh_reg;
                    R_T2CL:
                        if (w.operation == OP_WRITE) t2ll_next = w.data_value;
                        else
                        begin
                            ifr_next[FL_T2] = 1'b0;
                            rd_next = t2c_reg[7:0];
                        end
                    R_T2CH:
                        if (w.operation == OP_WRITE)
                        begin
                            t2c_next = {w.data_value, t2ll_reg};
                            ifr_next[FL_T2] = 1'b0;
                            t2run_next = 1'b1;
                        end
                        else rd_next = t2c_reg[15:8];
                    R_SR:
                    begin
                        if (w.operation == OP_WRITE) sdat_next = w.data_value;
                        else rd_next = sdat_reg;
                        ifr_next[FL_SR] = 1'b0;
                        if (srm != 3'd0)
                        begin
                            sbits_next = 4'd0;
                            srun_next = 1'b1;
                            if (!ext)
                                sdiv_next = (srm == 3'd2 || srm == 3'd6) ? 16'd2
                                          : {7'd0, ({1'b0, t2ll_reg} + 9'd2)};
                            if (!ext && !(srm == 3'd2 || srm == 3'd6))
                                sdiv_next = {6'd0, ({1'b0, t2ll_reg} + 9'd2), 1'b0};
                        end
                    end
                    R_ACR:
                        if (w.operation == OP_WRITE)
                        begin
                            acr_next = w.data_value;
                            if (w.data_value[4:2] == 3'd3 || w.data_value[4:2] == 3'd7)
                            begin
                                sbits_next = 4'd0;
                                srun_next = 1'b1;
                            end
                        end
                        else rd_next = acr_reg;
                    R_PCR:
                        if (w.operation == OP_WRITE)
                        begin
                            pcr_next = w.data_value;
                            if (w.data_value[3:1] == 3'd6) lv_next[4] = 1'b0;
                            else if (w.data_value[3:1] == 3'd7) lv_next[4] = 1'b1;
                            if (w.data_value[7:5] == 3'd6) lv_next[5] = 1'b0;
                            else if (w.data_value[7:5] == 3'd7) lv_next[5] = 1'b1;
                        end
                        else rd_next = pcr_reg;
                    R_IFR:
                        if (w.operation == OP_WRITE) ifr_next = ifr_reg & ~w.data_value[6:0];
                        else rd_next = {|(ifr_reg & ier_reg), ifr_reg};
                    R_IER:
                        if (w.operation == OP_WRITE)
                            ier_next = w.data_value[7] ? (ier_reg | w.data_value[6:0])
                                                       : (ier_reg & ~w.data_value[6:0]);
                        else rd_next = {1'b1, ier_reg};
                    R_ORAN:
                        if (w.operation == OP_WRITE) ora_next = w.data_value;
                        else rd_next = (ora_reg & ddra_reg) | (ina & ~ddra_reg);
                    default: ;
                endcase
            end
            OP_TICK:
            begin
                if (t1run_reg)
                begin
                    if (t1c_reg == 16'd0)
                    begin
                        ifr_next[FL_T1] = 1'b1;
                        if (acr_reg[6]) t1c_next = {t1lh_reg, t1ll_reg};
                        else
                        begin
                            t1run_next = 1'b0;
                            t1c_next = 16'hFFFF;
                        end
                    end
                    else t1c_next = t1c_reg - 16'd1;
                end
                if (t2run_reg)
                begin
                    if (t2c_reg == 16'd0)
                    begin
                        ifr_next[FL_T2] = 1'b1;
                        t2run_next = 1'b0;
                        t2c_next = 16'hFFFF;
                    end
                    else t2c_next = t2c_reg - 16'd1;
                end
                if (srun_reg && !ext)
                begin
                    sdiv_next = sdiv_reg - 16'd1;
                    if (sdiv_reg == 16'd1)
                    begin
                        if (srm >= 3'd1 && srm <= 3'd3) sbit = lv_reg[3];
                        else
                        begin
                            sbit = sdat_reg[7];
                            lv_next[5] = sbit;
                        end
                        sdat_next = {sdat_reg[6:0], sbit};
                        lv_next[6] = ~lv_reg[6];
                        bits = sbits_reg + 4'd1;
                        sbits_next = bits;
                        if (bits >= 4'd8)
                        begin
                            ifr_next[FL_SR] = 1'b1;
                            if (srm == 3'd4) sbits_next = 4'd0;
                            else srun_next = 1'b0;
                        end
                        sdiv_next = (srm == 3'd2 || srm == 3'd6) ? 16'd2
                                  : {6'd0, ({1'b0, t2ll_reg} + 9'd2), 1'b0};
                    end
                end
                if (ca2p_reg)
                begin
                    ca2p_next = 1'b0;
                    lv_next[4] = 1'b1;
                end
                if (cb2p_reg)
                begin
                    cb2p_next = 1'b0;
                    lv_next[5] = 1'b1;
                end
            end
            OP_PINS:
                if (w.port_select) pinb_next = w.data_value;
                else pina_next = w.data_value;
            OP_LINE1:
                if (!w.port_select)
                begin
                    act = pcr_reg[0] ? (!lv_reg[0] && w.line_level)
                                     : (lv_reg[0] && !w.line_level);
                    lv_next[0] = w.line_level;
                    if (act)
                    begin
                        if (acr_reg[0]) lata_next = pina_reg;
                        ifr_next[FL_CA1] = 1'b1;
                        if (pam == 3'd4) lv_next[4] = 1'b1;
                    end
                end
                else
                begin
                    act = pcr_reg[4] ? (!lv_reg[2] && w.line_level)
                                     : (lv_reg[2] && !w.line_level);
                    lv_next[2] = w.line_level;
                    if (act)
                    begin
                        if (srun_reg && ext)
                        begin
                            if (srm == 3'd3) sbit = lv_reg[3];
                            else
                            begin
                                sbit = sdat_reg[7];
                                lv_next[5] = sbit;
                            end
                            sdat_next = {sdat_reg[6:0], sbit};
                            lv_next[6] = ~lv_reg[6];
                            bits = sbits_reg + 4'd1;
                            sbits_next = bits;
                            if (bits >= 4'd8)
                            begin
                                ifr_next[FL_SR] = 1'b1;
                                srun_next = 1'b0;
                            end
                        end
                        else
                        begin
                            if (acr_reg[1]) latb_next = pinb_reg;
                            ifr_next[FL_CB1] = 1'b1;
                        end
                    end
                end
            OP_LINE2:
                if (!w.port_select)
                begin
                    if (pam <= 3'd3)
                    begin
                        act = pam[1] ? (!lv_reg[1] && w.line_level)
                                     : (lv_reg[1] && !w.line_level);
                        lv_next[1] = w.line_level;
                        if (act) ifr_next[FL_CA2] = 1'b1;
                    end
                end
                else
                begin
                    lv_next[3] = w.line_level;
                    if (srm == 3'd0 && pbm <= 3'd3)
                    begin
                        act = pbm[1] ? (!lv_reg[3] && w.line_level)
                                     : (lv_reg[3] && !w.line_level);
                        if (act) ifr_next[FL_CB2] = 1'b1;
                    end
                end
            default: ;
        endcase
    end

    always_comb
    begin
        res_next.read_data       = rd_next;
        res_next.irq             = |(ifr_next & ier_next);
        res_next.port_a_pins     = (ora_next & ddra_next) | (pina_next & ~ddra_next);
        res_next.port_b_pins     = (orb_next & ddrb_next) | (pinb_next & ~ddrb_next);
        res_next.ca1_level       = lv_next[0];
        res_next.cb1_line        = lv_next[6];
        res_next.ca2_line        = lv_next[4];
        res_next.cb2_line        = lv_next[5];
        res_next.interrupt_flags = ifr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ora_reg <= '0; orb_reg <= '0; ddra_reg <= '0; ddrb_reg <= '0;
            lata_reg <= '0; latb_reg <= '0; pina_reg <= '0; pinb_reg <= '0;
            t1c_reg <= '0; t2c_reg <= '0; sdiv_reg <= '0; t1ll_reg <= '0;
            t1lh_reg <= '0; t2ll_reg <= '0; sdat_reg <= '0; acr_reg <= '0;
            pcr_reg <= '0; t1run_reg <= 1'b0; t2run_reg <= 1'b0; srun_reg <= 1'b0;
            ca2p_reg <= 1'b0; cb2p_reg <= 1'b0; sbits_reg <= '0; ifr_reg <= '0;
            ier_reg <= '0; lv_reg <= '1; full_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                ora_reg <= ora_next; orb_reg <= orb_next; ddra_reg <= ddra_next;
                ddrb_reg <= ddrb_next; lata_reg <= lata_next; latb_reg <= latb_next;
                pina_reg <= pina_next; pinb_reg <= pinb_next; t1c_reg <= t1c_next;
                t2c_reg <= t2c_next; sdiv_reg <= sdiv_next; t1ll_reg <= t1ll_next;
                t1lh_reg <= t1lh_next; t2ll_reg <= t2ll_next; sdat_reg <= sdat_next;
                acr_reg <= acr_next; pcr_reg <= pcr_next; t1run_reg <= t1run_next;
                t2run_reg <= t2run_next; srun_reg <= srun_next; ca2p_reg <= ca2p_next;
                cb2p_reg <= cb2p_next; sbits_reg <= sbits_next; ifr_reg <= ifr_next;
                ier_reg <= ier_next; lv_reg <= lv_next;
                full_reg <= 1'b1;
            end
            else if (out.ready)
                full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) res_reg <= res_next;
    end

endmodule

// ===== sv/via_checker.sv =====
`include "versatile_interface_adapter_core_assert.svh"
module via_checker
    import via_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input via_out_t out_data
);
    // A result must follow every accepted word.
    `VIA_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)
    // The input is open whenever no result is waiting.
    `VIA_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
    // irq is never raised with no flag set.
    `VIA_ASSERT_IMP(a_irq_flags, clk, rst_n, out_valid && out_data.irq,
        out_data.interrupt_flags != 7'd0)
    // A stalled result holds its value.
    `VIA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(out_data))
endmodule

bind versatile_interface_adapter_core via_checker u_via_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .out_data  (out.data)
);

// ===== tb/testbench.sv =====
module testbench;
    import via_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    via_if #(.T(via_in_t))  in_ch ();
    via_if #(.T(via_out_t)) out_ch ();

    versatile_interface_adapter_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    // The clock runs with a 10 ns period, high and low for half of it each.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mirror of the adapter's registers, kept by the predictor below.
    logic [7:0]  m_ora, m_orb, m_ddra, m_ddrb, m_lat_a, m_lat_b, m_pin_a, m_pin_b;
    logic [15:0] m_t1, m_t2, m_sr_div;
    logic [7:0]  m_t1l_lo, m_t1l_hi, m_t2l_lo, m_sr, m_acr, m_pcr;
    logic        m_t1_run, m_t2_run, m_sr_run, m_ca2_pend, m_cb2_pend;
    logic [3:0]  m_sr_cnt;
    logic [6:0]  m_ifr, m_ier, m_lines;

    // Bit positions within the line level mirror.
    localparam int LN_CA1_IN  = 0;
    localparam int LN_CA2_IN  = 1;
    localparam int LN_CB1_IN  = 2;
    localparam int LN_CB2_IN  = 3;
    localparam int LN_CA2_OUT = 4;
    localparam int LN_CB2_OUT = 5;
    localparam int LN_CB1_OUT = 6;

    via_out_t expected_words[$];
    int  error_count;
    int  idle_cycles;
    logic sink_hold;   // forces the receiver to stall for a long stretch

    function automatic logic [2:0] sr_mode();
        return m_acr[4:2];
    endfunction

    function automatic logic sr_ext(logic [2:0] m);
        return (m == 3'd3) || (m == 3'd7);
    endfunction

    function automatic logic [15:0] sr_reload(logic [2:0] m);
        if (m == 3'd2 || m == 3'd6)
            return 16'd2;
        return 16'(2 * (int'(m_t2l_lo) + 2));
    endfunction

    function automatic logic [7:0] port_a_value();
        logic [7:0] src;
        src = m_acr[0] ? m_lat_a : m_pin_a;
        return (m_ora & m_ddra) | (src & ~m_ddra);
    endfunction

    function automatic logic [7:0] port_b_value();
        logic [7:0] src;
        src = m_acr[1] ? m_lat_b : m_pin_b;
        return (m_orb & m_ddrb) | (src & ~m_ddrb);
    endfunction

    task automatic mirror_reset();
        m_ora = '0; m_orb = '0; m_ddra = '0; m_ddrb = '0;
        m_lat_a = '0; m_lat_b = '0; m_pin_a = '0; m_pin_b = '0;
        m_t1 = '0; m_t2 = '0; m_sr_div = '0;
        m_t1l_lo = '0; m_t1l_hi = '0; m_t2l_lo = '0; m_sr = '0; m_acr = '0; m_pcr = '0;
        m_t1_run = 0; m_t2_run = 0; m_sr_run = 0; m_ca2_pend = 0; m_cb2_pend = 0;
        m_sr_cnt = '0; m_ifr = '0; m_ier = '0; m_lines = 7'h7F;
    endtask

    // Handshake side effects of an access to port A or port B.
    task automatic access_a();
        logic [2:0] m;
        m = m_pcr[3:1];
        m_ifr[FL_CA1] = 1'b0;
        if (m != 3'd1 && m != 3'd3)
            m_ifr[FL_CA2] = 1'b0;
        if (m == 3'd4 || m == 3'd5)
            m_lines[LN_CA2_OUT] = 1'b0;
        if (m == 3'd5)
            m_ca2_pend = 1'b1;
    endtask

    task automatic access_b();
        logic [2:0] m;
        m = m_pcr[7:5];
        m_ifr[FL_CB1] = 1'b0;
        if (m != 3'd1 && m != 3'd3)
            m_ifr[FL_CB2] = 1'b0;
        // The CB2 handshake is suppressed while the shift register is in use.
        if (sr_mode() == 3'd0)
        begin
            if (m == 3'd4 || m == 3'd5)
                m_lines[LN_CB2_OUT] = 1'b0;
            if (m == 3'd5)
                m_cb2_pend = 1'b1;
        end
    endtask

    task automatic sr_begin();
        logic [2:0] m;
        m = sr_mode();
        if (m != 3'd0)
        begin
            m_sr_cnt = '0;
            m_sr_run = 1'b1;
            if (!sr_ext(m))
                m_sr_div = sr_reload(m);
        end
    endtask

    // One shift step; mode 0 behaves as an output mode if left running.
    task automatic sr_step();
        logic [2:0] m;
        logic b;
        m = sr_mode();
        if (m >= 3'd1 && m <= 3'd3)
            b = m_lines[LN_CB2_IN];
        else
        begin
            b = m_sr[7];
            m_lines[LN_CB2_OUT] = b;
        end
        m_sr = {m_sr[6:0], b};
        m_lines[LN_CB1_OUT] = ~m_lines[LN_CB1_OUT];
        m_sr_cnt = m_sr_cnt + 4'd1;
        if (m_sr_cnt >= 4'd8)
        begin
            m_ifr[FL_SR] = 1'b1;
            if (m == 3'd4)
                m_sr_cnt = '0;
            else
                m_sr_run = 1'b0;
        end
    endtask

    task automatic predict_read(logic [3:0] r, output logic [7:0] rd);
        case (r)
            R_ORB:  begin access_b(); rd = port_b_value(); end
            R_ORA:  begin access_a(); rd = port_a_value(); end
            R_DDRB: rd = m_ddrb;
            R_DDRA: rd = m_ddra;
            R_T1CL: begin m_ifr[FL_T1] = 1'b0; rd = m_t1[7:0]; end
            R_T1CH: rd = m_t1[15:8];
            R_T1LL: rd = m_t1l_lo;
            R_T1LH: rd = m_t1l_hi;
            R_T2CL: begin m_ifr[FL_T2] = 1'b0; rd = m_t2[7:0]; end
            R_T2CH: rd = m_t2[15:8];
            R_SR:   begin m_ifr[FL_SR] = 1'b0; sr_begin(); rd = m_sr; end
            R_ACR:  rd = m_acr;
            R_PCR:  rd = m_pcr;
            R_IFR:  rd = {|(m_ifr & m_ier), m_ifr};
            R_IER:  rd = {1'b1, m_ier};
            default: rd = port_a_value();
        endcase
    endtask

    task automatic predict_write(logic [3:0] r, logic [7:0] v);
        case (r)
            R_ORB:  begin m_orb = v; access_b(); end
            R_ORA:  begin m_ora = v; access_a(); end
            R_DDRB: m_ddrb = v;
            R_DDRA: m_ddra = v;
            R_T1CL, R_T1LL: m_t1l_lo = v;
            R_T1CH:
            begin
                m_t1l_hi = v;
                m_t1 = {v, m_t1l_lo};
                m_ifr[FL_T1] = 1'b0;
                m_t1_run = 1'b1;
            end
            R_T1LH: begin m_t1l_hi = v; m_ifr[FL_T1] = 1'b0; end
            R_T2CL: m_t2l_lo = v;
            R_T2CH:
            begin
                m_t2 = {v, m_t2l_lo};
                m_ifr[FL_T2] = 1'b0;
                m_t2_run = 1'b1;
            end
            R_SR:   begin m_sr = v; m_ifr[FL_SR] = 1'b0; sr_begin(); end
            R_ACR:
            begin
                m_acr = v;
                if (sr_ext(sr_mode()))
                begin
                    m_sr_cnt = '0;
                    m_sr_run = 1'b1;
                end
            end
            R_PCR:
            begin
                m_pcr = v;
                if (v[3:1] == 3'd6)
                    m_lines[LN_CA2_OUT] = 1'b0;
                else if (v[3:1] == 3'd7)
                    m_lines[LN_CA2_OUT] = 1'b1;
                if (v[7:5] == 3'd6)
                    m_lines[LN_CB2_OUT] = 1'b0;
                else if (v[7:5] == 3'd7)
                    m_lines[LN_CB2_OUT] = 1'b1;
            end
            R_IFR:  m_ifr = m_ifr & ~v[6:0];
            R_IER:
            begin
                if (v[7])
                    m_ier = m_ier | v[6:0];
                else
                    m_ier = m_ier & ~v[6:0];
            end
            default: m_ora = v;
        endcase
    endtask

    task automatic predict_tick();
        logic [2:0] m;
        if (m_t1_run)
        begin
            if (m_t1 == 16'h0000)
            begin
                m_ifr[FL_T1] = 1'b1;
                if (m_acr[6])
                    m_t1 = {m_t1l_hi, m_t1l_lo};
                else
                begin
                    m_t1_run = 1'b0;
                    m_t1 = 16'hFFFF;
                end
            end
            else
                m_t1 = m_t1 - 16'd1;
        end
        if (m_t2_run)
        begin
            if (m_t2 == 16'h0000)
            begin
                m_ifr[FL_T2] = 1'b1;
                m_t2_run = 1'b0;
                m_t2 = 16'hFFFF;
            end
            else
                m_t2 = m_t2 - 16'd1;
        end
        if (m_sr_run)
        begin
            m = sr_mode();
            if (!sr_ext(m))
            begin
                // The divider is a plain 16-bit down counter and may wrap.
                m_sr_div = m_sr_div - 16'd1;
                if (m_sr_div == 16'h0000)
                begin
                    sr_step();
                    m_sr_div = sr_reload(m);
                end
            end
        end
        if (m_ca2_pend)
        begin
            m_ca2_pend = 1'b0;
            m_lines[LN_CA2_OUT] = 1'b1;
        end
        if (m_cb2_pend)
        begin
            m_cb2_pend = 1'b0;
            m_lines[LN_CB2_OUT] = 1'b1;
        end
    endtask

    task automatic predict_line1(logic side, logic lvl);
        logic act;
        logic [2:0] m;
        if (!side)
        begin
            act = m_pcr[0] ? (!m_lines[LN_CA1_IN] && lvl) : (m_lines[LN_CA1_IN] && !lvl);
            m_lines[LN_CA1_IN] = lvl;
            if (act)
            begin
                if (m_acr[0])
                    m_lat_a = m_pin_a;
                m_ifr[FL_CA1] = 1'b1;
                if (m_pcr[3:1] == 3'd4)
                    m_lines[LN_CA2_OUT] = 1'b1;
            end
        end
        else
        begin
            act = m_pcr[4] ? (!m_lines[LN_CB1_IN] && lvl) : (m_lines[LN_CB1_IN] && !lvl);
            m = sr_mode();
            m_lines[LN_CB1_IN] = lvl;
            if (act)
            begin
                // An external shift clock edge shifts instead of flagging CB1.
                if (m_sr_run && sr_ext(m))
                    sr_step();
                else
                begin
                    if (m_acr[1])
                        m_lat_b = m_pin_b;
                    m_ifr[FL_CB1] = 1'b1;
                end
            end
        end
    endtask

    task automatic predict_line2(logic side, logic lvl);
        logic [2:0] m;
        logic act;
        if (!side)
        begin
            m = m_pcr[3:1];
            // CA2 as an output ignores the external level.
            if (m <= 3'd3)
            begin
                act = (m >= 3'd2) ? (!m_lines[LN_CA2_IN] && lvl)
                                  : (m_lines[LN_CA2_IN] && !lvl);
                m_lines[LN_CA2_IN] = lvl;
                if (act)
                    m_ifr[FL_CA2] = 1'b1;
            end
        end
        else
        begin
            m = m_pcr[7:5];
            if (sr_mode() != 3'd0 || m > 3'd3)
                m_lines[LN_CB2_IN] = lvl;
            else
            begin
                act = (m >= 3'd2) ? (!m_lines[LN_CB2_IN] && lvl)
                                  : (m_lines[LN_CB2_IN] && !lvl);
                m_lines[LN_CB2_IN] = lvl;
                if (act)
                    m_ifr[FL_CB2] = 1'b1;
            end
        end
    endtask

    // Advances the mirror by one operation and returns the word it should produce.
    task automatic predict_word(via_in_t w, output via_out_t e);
        logic [7:0] rd;
        rd = '0;
        case (via_op_t'(w.operation))
            OP_READ:  predict_read(w.reg_index, rd);
            OP_WRITE: predict_write(w.reg_index, w.data_value);
            OP_TICK:  predict_tick();
            OP_PINS:
            begin
                if (w.port_select)
                    m_pin_b = w.data_value;
                else
                    m_pin_a = w.data_value;
            end
            OP_LINE1: predict_line1(w.port_select, w.line_level);
            OP_LINE2: predict_line2(w.port_select, w.line_level);
            default: ;
        endcase
        e.read_data       = rd;
        e.irq             = |(m_ifr & m_ier);
        e.port_a_pins     = (m_ora & m_ddra) | (m_pin_a & ~m_ddra);
        e.port_b_pins     = (m_orb & m_ddrb) | (m_pin_b & ~m_ddrb);
        e.ca1_level       = m_lines[LN_CA1_IN];
        e.cb1_line        = m_lines[LN_CB1_OUT];
        e.ca2_line        = m_lines[LN_CA2_OUT];
        e.cb2_line        = m_lines[LN_CB2_OUT];
        e.interrupt_flags = m_ifr;
    endtask

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one word, with a random gap in front, and waits until it is taken.
    // The expectation is queued at the accepting edge, before the result can come.
    // With no gap the next word follows directly and valid stays high.
    task automatic send_word(via_in_t w);
        via_out_t e;
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_word(w, e);
        expected_words.push_back(e);
    endtask

    task automatic send_op(via_op_t op, logic [3:0] r, logic [7:0] d, logic s, logic l);
        via_in_t w;
        w.operation   = op;
        w.reg_index   = r;
        w.data_value  = d;
        w.port_select = s;
        w.line_level  = l;
        send_word(w);
    endtask

    task automatic bus_write(logic [3:0] r, logic [7:0] d);
        send_op(OP_WRITE, r, d, 1'b0, 1'b0);
    endtask

    task automatic bus_read(logic [3:0] r);
        send_op(OP_READ, r, 8'h00, 1'b0, 1'b0);
    endtask

    task automatic ticks(int n);
        repeat (n)
            send_op(OP_TICK, 4'd0, 8'h00, 1'b0, 1'b0);
    endtask

    // Extremes of the fields, every register, both sides and the spare codes.
    task automatic test_registers();
        bus_write(R_DDRA, 8'hFF);
        bus_write(R_ORA, 8'hA5);
        bus_write(R_DDRB, 8'h0F);
        bus_write(R_ORB, 8'hFF);
        send_op(OP_PINS, 4'd0, 8'hFF, 1'b1, 1'b0);
        send_op(OP_PINS, 4'd0, 8'h00, 1'b0, 1'b0);
        for (int r = 0; r < 16; r++)
            bus_read(4'(r));
        bus_write(R_IER, 8'hFF);
        bus_write(R_ORAN, 8'h5A);
        bus_read(R_IER);
        send_op(OP_SPARE6, 4'hF, 8'hFF, 1'b1, 1'b1);
        send_op(OP_SPARE7, 4'hF, 8'hFF, 1'b1, 1'b1);
    endtask

    // Timer expiry in one-shot and free-run modes.
    task automatic test_timers();
        bus_write(R_T1LL, 8'h02);
        bus_write(R_T1CH, 8'h00);
        bus_write(R_T2CL, 8'h01);
        bus_write(R_T2CH, 8'h00);
        ticks(5);
        bus_read(R_T1CL);
        bus_read(R_T2CH);
        bus_write(R_ACR, 8'h40);
        bus_write(R_T1CH, 8'h00);
        ticks(8);
        bus_read(R_IFR);
    endtask

    // Shift register in its timer 2, system clock and external CB1 clock modes.
    task automatic test_shift();
        bus_write(R_T2CL, 8'h00);
        bus_write(R_ACR, 8'h14);
        bus_write(R_SR, 8'hC3);
        ticks(40);
        bus_write(R_ACR, 8'h08);
        bus_read(R_SR);
        ticks(20);
        bus_write(R_ACR, 8'h00);
        ticks(10);
        bus_write(R_ACR, 8'h1C);
        for (int i = 0; i < 20; i++)
            send_op(OP_LINE1, 4'd0, 8'h00, 1'b1, 1'(i));
        bus_read(R_SR);
        bus_write(R_ACR, 8'h00);
    endtask

    // Control lines through every PCR mode, on both sides.
    task automatic test_lines();
        for (int m = 0; m < 8; m++)
        begin
            bus_write(R_PCR, {3'(m), 1'(m), 3'(m), 1'(m)});
            bus_write(R_ACR, 8'(m & 3));
            send_op(OP_LINE1, 4'd0, 8'h00, 1'b0, 1'b0);
            send_op(OP_LINE1, 4'd0, 8'h00, 1'b0, 1'b1);
            send_op(OP_LINE1, 4'd0, 8'h00, 1'b1, 1'b0);
            send_op(OP_LINE1, 4'd0, 8'h00, 1'b1, 1'b1);
            send_op(OP_LINE2, 4'd0, 8'h00, 1'b0, 1'b0);
            send_op(OP_LINE2, 4'd0, 8'h00, 1'b0, 1'b1);
            send_op(OP_LINE2, 4'd0, 8'h00, 1'b1, 1'b0);
            send_op(OP_LINE2, 4'd0, 8'h00, 1'b1, 1'b1);
            bus_read(R_ORA);
            bus_read(R_ORB);
            ticks(2);
            bus_write(R_ORA, 8'h3C);
            bus_write(R_ORB, 8'hC3);
            ticks(1);
        end
    endtask

    // Random words: reads, writes, ticks, pins, line activity and spare codes, with mostly short timer counts.
    task automatic test_random(int n);
        via_in_t w;
        int p;
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(0, 99);
            w.reg_index   = 4'($urandom_range(0, 15));
            w.data_value  = 8'($urandom);
            w.port_select = 1'($urandom);
            w.line_level  = 1'($urandom);
            if (p < 20)
                w.operation = OP_READ;
            else if (p < 40)
                w.operation = OP_WRITE;
            else if (p < 70)
                w.operation = OP_TICK;
            else if (p < 78)
                w.operation = OP_PINS;
            else if (p < 88)
                w.operation = OP_LINE1;
            else if (p < 97)
                w.operation = OP_LINE2;
            else
                w.operation = 3'($urandom_range(6, 7));
            // Keep timer counts short so that they expire within the run.
            if (w.operation == OP_WRITE &&
                (w.reg_index == R_T1CH || w.reg_index == R_T2CH || w.reg_index == R_T1LH)
                && $urandom_range(0, 9) != 0)
                w.data_value = 8'h00;
            if (w.operation == OP_WRITE && (w.reg_index == R_T2CL || w.reg_index == R_T1LL
                || w.reg_index == R_T1CL) && $urandom_range(0, 3) != 0)
                w.data_value = 8'($urandom_range(0, 6));
            send_word(w);
        end
    endtask

    // The receiver stalls for a long stretch while words keep coming.
    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                repeat (60)
                    @(posedge clk);
                sink_hold = 1'b0;
            end
            test_random(20);
        join
    endtask

    initial
    begin
        error_count = 0;
        sink_hold = 1'b0;
        mirror_reset();
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        rst_n = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_registers();
        test_timers();
        test_shift();
        test_lines();
        test_backpressure();
        test_random(845);
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (5)
            @(posedge clk);
        if (error_count == 0)
            $display("** versatile_interface_adapter_core: PASSED **");
        else
            $display("** versatile_interface_adapter_core: FAILED **");
        $finish;
    end

    // Receiver: random stalls, plus the long hold during the back-pressure test.
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = gap_length();
            if (gap > 0 || sink_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap > 0 ? gap : 1)
                    @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        via_out_t e;
        via_out_t a;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            a = out_ch.data;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, a);
                error_count++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (a.read_data !== e.read_data || a.irq !== e.irq ||
                    a.port_a_pins !== e.port_a_pins || a.port_b_pins !== e.port_b_pins ||
                    a.ca1_level !== e.ca1_level || a.cb1_line !== e.cb1_line ||
                    a.ca2_line !== e.ca2_line || a.cb2_line !== e.cb2_line ||
                    a.interrupt_flags !== e.interrupt_flags)
                begin
                    $display("%0t: mismatch, expected %h, actual %h", $time, e, a);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any word accepted on either side ends the run.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= 2000)
        begin
            $display("** versatile_interface_adapter_core: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
